// ----- hdl/tcst_pkg.sv -----
// Shared types and constants for the time-code slot transmitter.
package tcst_pkg;

   localparam int CMD_W       = 2;
   localparam int SLOT_W      = 6;
   localparam int SYMBOL_W    = 2;
   localparam int TIMESTAMP_W = 48;
   localparam int LOW_TIME_W  = 20;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE   = 2'd0,
      CMD_READY   = 2'd1,
      CMD_TICK    = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [SYMBOL_W-1:0] {
      SYM_ZERO   = 2'd0,
      SYM_ONE    = 2'd1,
      SYM_MARKER = 2'd2,
      SYM_NONE   = 2'd3
   } symbol_type;

   localparam logic [LOW_TIME_W-1:0] LOW_TIME_ZERO_US   = 20'd200000;
   localparam logic [LOW_TIME_W-1:0] LOW_TIME_ONE_US    = 20'd500000;
   localparam logic [LOW_TIME_W-1:0] LOW_TIME_MARKER_US = 20'd800000;
   localparam logic [LOW_TIME_W-1:0] LOW_TIME_NONE_US   = 20'd0;

   localparam longint unsigned USEC_SECOND = 64'd1000000;
   localparam longint unsigned USEC_MINUTE = 64'd60000000;

endpackage

// ----- hdl/tcst_channels.sv -----
// Request and response channel interfaces for the time-code slot transmitter.
interface tcst_req_if;
   import tcst_pkg::*;

   logic                   valid;
   logic                   ready;
   cmd_type                cmd;
   logic                   to_active;
   logic [SLOT_W-1:0]      slot_index;
   symbol_type             symbol;
   logic [TIMESTAMP_W-1:0] timestamp_us;

   modport source (output valid, cmd, to_active, slot_index, symbol, timestamp_us,
                   input ready);
   modport sink   (input valid, cmd, to_active, slot_index, symbol, timestamp_us,
                   output ready);
endinterface

interface tcst_rsp_if;
   import tcst_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SLOT_W-1:0]      sent_slot;
   symbol_type             sent_symbol;
   logic                   carrier_off;
   logic [LOW_TIME_W-1:0]  low_time_us;
   logic                   frame_swapped;
   logic                   frame_request;
   logic                   minute_done;
   logic [TIMESTAMP_W-1:0] tick_interval_us;
   logic [TIMESTAMP_W-1:0] peak_second_jitter_us;
   logic [TIMESTAMP_W-1:0] minute_length_us;
   logic [TIMESTAMP_W-1:0] peak_minute_drift_us;

   modport source (output valid, sent_slot, sent_symbol, carrier_off, low_time_us,
                   frame_swapped, frame_request, minute_done, tick_interval_us,
                   peak_second_jitter_us, minute_length_us, peak_minute_drift_us,
                   input ready);
   modport sink   (input valid, sent_slot, sent_symbol, carrier_off, low_time_us,
                   frame_swapped, frame_request, minute_done, tick_interval_us,
                   peak_second_jitter_us, minute_length_us, peak_minute_drift_us,
                   output ready);
endinterface

// ----- hdl/tcst_frame_store.sv -----
// One frame buffer: symbol memory with per-slot valid bits and write forwarding.
module tcst_frame_store #(
   parameter int DEPTH = 60
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [$clog2(DEPTH)-1:0]             wr_addr,
   input  tcst_pkg::symbol_type                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]             rd_addr,
   output tcst_pkg::symbol_type                 rd_data
);
   import tcst_pkg::*;

   symbol_type       mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   symbol_type       rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else if (valid_ff[rd_addr]) begin
         rd_data_ff <= mem_ff[rd_addr];
      end else begin
         rd_data_ff <= SYM_ZERO;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/time_code_slot_transmitter_unit.sv -----
// Top level of the time-code slot transmitter.
//
// Usage: requests enter on req_if (valid/ready). A write request loads one
// symbol into the staging or active frame, a ready request marks staging
// complete, a restart request returns the slot counter to 0, and a tick
// request sends the current slot and yields one response on rsp_if.
// Other requests yield no response.
// Path: a tick in the input register passes through one logic stage into
// the response register, which then shows its response valid.
// Throughput: one request per cycle unless a tick waits on a response,
// set by the single processing stage; both frame memories are read every
// cycle at the upcoming slot; writes forward into registered read data.
// Reset: control state clears; both frames read as zero symbols through
// per-slot valid bits, so there is no clearing pass.
// Stall: while a response waits, a tick in the input register holds and
// ready drops; non-tick requests still pass through.
module time_code_slot_transmitter_unit #(
   parameter int SLOTS_PER_FRAME = 60,
   parameter int TIME_BITS       = 48
) (
   input logic        clock,
   input logic        reset,
   tcst_req_if.sink   req_if,
   tcst_rsp_if.source rsp_if
);
   import tcst_pkg::*;

   localparam int AW = $clog2(SLOTS_PER_FRAME);
   localparam int TW = TIME_BITS;
   localparam logic [AW:0] SLOTS_LIMIT = (AW+1)'(SLOTS_PER_FRAME);
   localparam logic [TW-1:0] SEC_NOM = TW'(USEC_SECOND);
   localparam logic [TW-1:0] MIN_NOM = TW'(USEC_MINUTE);

   function automatic logic [TW-1:0] abs_dev(input logic [TW-1:0] v,
                                             input logic [TW-1:0] nom);
      return (v >= nom) ? (v - nom) : (nom - v);
   endfunction

   // input register
   logic                   in_valid_ff;
   cmd_type                in_cmd_ff;
   logic                   in_to_active_ff;
   logic [SLOT_W-1:0]      in_slot_ff;
   symbol_type             in_symbol_ff;
   logic [TIMESTAMP_W-1:0] in_time_ff;

   // block state
   logic          active_is_b_ff, active_is_b_in;
   logic          staging_ready_ff, staging_ready_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [TW-1:0] prev_tick_ff, prev_tick_in;
   logic          prev_tick_valid_ff, prev_tick_valid_in;
   logic [TW-1:0] prev_min_ff, prev_min_in;
   logic          prev_min_valid_ff, prev_min_valid_in;
   logic [TW-1:0] min_len_ff, min_len_in;
   logic [TW-1:0] max_jit_ff, max_jit_in;
   logic [TW-1:0] max_drift_ff, max_drift_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   symbol_type            rsp_symbol_ff;
   logic                  rsp_carrier_ff;
   logic [LOW_TIME_W-1:0] rsp_low_ff, low_time;
   logic                  rsp_swapped_ff, swapped;
   logic                  rsp_request_ff, request;
   logic                  rsp_wrapped_ff, wrapped;
   logic [TW-1:0]         rsp_period_ff, sec_period;

   logic          rsp_free, fire, tick_fire, req_ready;
   logic          to_b, wr_ok, wr_a_en, wr_b_en;
   logic [AW-1:0] wr_addr;
   symbol_type    rd_a, rd_b, cur_symbol;
   logic [TW-1:0] now, jitter, min_len, drift;
   logic [AW:0]   slot_next;

   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;
   assign fire      = in_valid_ff && ((in_cmd_ff != CMD_TICK) || rsp_free);
   assign tick_fire = fire && (in_cmd_ff == CMD_TICK);
   assign req_ready = !in_valid_ff || fire;
   assign req_if.ready = req_ready;

   // symbol writes
   assign to_b    = in_to_active_ff ? active_is_b_ff : !active_is_b_ff;
   assign wr_ok   = fire && (in_cmd_ff == CMD_WRITE)
                    && ({1'b0, in_slot_ff} < (SLOT_W+1)'(SLOTS_PER_FRAME));
   assign wr_a_en = wr_ok && !to_b;
   assign wr_b_en = wr_ok && to_b;
   assign wr_addr = in_slot_ff[AW-1:0];

   tcst_frame_store #(.DEPTH(SLOTS_PER_FRAME)) u_store_a (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_a_en),
      .wr_addr (wr_addr),
      .wr_data (in_symbol_ff),
      .rd_addr (slot_in),
      .rd_data (rd_a)
   );

   tcst_frame_store #(.DEPTH(SLOTS_PER_FRAME)) u_store_b (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_b_en),
      .wr_addr (wr_addr),
      .wr_data (in_symbol_ff),
      .rd_addr (slot_in),
      .rd_data (rd_b)
   );

   assign now = TW'(in_time_ff);

   always_comb begin
      active_is_b_in     = active_is_b_ff;
      staging_ready_in   = staging_ready_ff;
      slot_in            = slot_ff;
      prev_tick_in       = prev_tick_ff;
      prev_tick_valid_in = prev_tick_valid_ff;
      prev_min_in        = prev_min_ff;
      prev_min_valid_in  = prev_min_valid_ff;
      min_len_in         = min_len_ff;
      max_jit_in         = max_jit_ff;
      max_drift_in       = max_drift_ff;
      swapped            = 1'b0;
      request            = 1'b0;
      wrapped            = 1'b0;

      sec_period = prev_tick_valid_ff ? (now - prev_tick_ff) : '0;
      jitter     = abs_dev(sec_period, SEC_NOM);
      min_len    = now - prev_min_ff;
      drift      = abs_dev(min_len, MIN_NOM);
      slot_next  = {1'b0, slot_ff} + (AW+1)'(1);

      if (fire) begin
         case (in_cmd_ff)
            CMD_READY: begin
               staging_ready_in = 1'b1;
            end
            CMD_RESTART: begin
               slot_in = '0;
            end
            CMD_TICK: begin
               if (prev_tick_valid_ff && (jitter > max_jit_ff)) begin
                  max_jit_in = jitter;
               end
               prev_tick_in       = now;
               prev_tick_valid_in = 1'b1;
               if (slot_ff == '0) begin
                  if (prev_min_valid_ff) begin
                     min_len_in = min_len;
                     if (drift > max_drift_ff) begin
                        max_drift_in = drift;
                     end
                  end
                  prev_min_in       = now;
                  prev_min_valid_in = 1'b1;
                  if (staging_ready_ff) begin
                     active_is_b_in   = !active_is_b_ff;
                     staging_ready_in = 1'b0;
                     swapped          = 1'b1;
                  end
                  request = 1'b1;
               end
               if (slot_next >= SLOTS_LIMIT) begin
                  slot_in = '0;
                  wrapped = 1'b1;
               end else begin
                  slot_in = slot_next[AW-1:0];
               end
            end
            default: begin
            end
         endcase
      end

      cur_symbol = active_is_b_in ? rd_b : rd_a;
      case (cur_symbol)
         SYM_ZERO:   low_time = LOW_TIME_ZERO_US;
         SYM_ONE:    low_time = LOW_TIME_ONE_US;
         SYM_MARKER: low_time = LOW_TIME_MARKER_US;
         default:    low_time = LOW_TIME_NONE_US;
      endcase

      rsp_valid_in = tick_fire ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         active_is_b_ff     <= 1'b0;
         staging_ready_ff   <= 1'b0;
         slot_ff            <= '0;
         prev_tick_ff       <= '0;
         prev_tick_valid_ff <= 1'b0;
         prev_min_ff        <= '0;
         prev_min_valid_ff  <= 1'b0;
         min_len_ff         <= '0;
         max_jit_ff         <= '0;
         max_drift_ff       <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_if.valid;
         end
         rsp_valid_ff       <= rsp_valid_in;
         active_is_b_ff     <= active_is_b_in;
         staging_ready_ff   <= staging_ready_in;
         slot_ff            <= slot_in;
         prev_tick_ff       <= prev_tick_in;
         prev_tick_valid_ff <= prev_tick_valid_in;
         prev_min_ff        <= prev_min_in;
         prev_min_valid_ff  <= prev_min_valid_in;
         min_len_ff         <= min_len_in;
         max_jit_ff         <= max_jit_in;
         max_drift_ff       <= max_drift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_if.valid) begin
         in_cmd_ff       <= req_if.cmd;
         in_to_active_ff <= req_if.to_active;
         in_slot_ff      <= req_if.slot_index;
         in_symbol_ff    <= req_if.symbol;
         in_time_ff      <= req_if.timestamp_us;
      end
      if (tick_fire) begin
         rsp_slot_ff    <= SLOT_W'(slot_ff);
         rsp_symbol_ff  <= cur_symbol;
         rsp_carrier_ff <= (cur_symbol != SYM_NONE);
         rsp_low_ff     <= low_time;
         rsp_swapped_ff <= swapped;
         rsp_request_ff <= request;
         rsp_wrapped_ff <= wrapped;
         rsp_period_ff  <= sec_period;
      end
   end

   assign rsp_if.valid                 = rsp_valid_ff;
   assign rsp_if.sent_slot             = rsp_slot_ff;
   assign rsp_if.sent_symbol           = rsp_symbol_ff;
   assign rsp_if.carrier_off           = rsp_carrier_ff;
   assign rsp_if.low_time_us           = rsp_low_ff;
   assign rsp_if.frame_swapped         = rsp_swapped_ff;
   assign rsp_if.frame_request         = rsp_request_ff;
   assign rsp_if.minute_done           = rsp_wrapped_ff;
   assign rsp_if.tick_interval_us      = TIMESTAMP_W'(rsp_period_ff);
   // stats are reported as of the latest tick; state only moves on ticks
   assign rsp_if.peak_second_jitter_us = TIMESTAMP_W'(max_jit_ff);
   assign rsp_if.minute_length_us      = TIMESTAMP_W'(min_len_ff);
   assign rsp_if.peak_minute_drift_us  = TIMESTAMP_W'(max_drift_ff);

   ap_tick_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> rsp_valid_ff)
      else $error("tick request did not produce a response");

   ap_swap_at_slot0: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_swapped_ff) |-> (rsp_request_ff && (rsp_slot_ff == '0)))
      else $error("frame swap outside slot 0");

   ap_slot_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, slot_ff} < SLOTS_LIMIT)
      else $error("slot counter out of range");

   ap_restart_zero: assert property (@(posedge clock) disable iff (reset)
      (fire && (in_cmd_ff == CMD_RESTART)) |=> (slot_ff == '0))
      else $error("restart did not clear slot counter");

endmodule

// ----- sim/time_code_slot_transmitter_unit_test.sv -----
// Testbench for the time-code slot transmitter: directed and random requests, checked per slot.
module time_code_slot_transmitter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tcst_pkg::*;

   localparam int SLOTS        = 60;
   localparam int ITEM_TARGET  = 950;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [TIMESTAMP_W-1:0] TIME_MAX = '1;

   typedef struct {
      cmd_type                cmd;
      logic                   to_active;
      logic [SLOT_W-1:0]      slot_index;
      symbol_type             symbol;
      logic [TIMESTAMP_W-1:0] timestamp_us;
   } slot_request_type;

   typedef struct {
      logic [SLOT_W-1:0]      slot;
      symbol_type             symbol;
      logic                   carrier_off;
      logic [LOW_TIME_W-1:0]  low_time;
      logic                   swapped;
      logic                   request;
      logic                   wrapped;
      logic [TIMESTAMP_W-1:0] second_period;
      logic [TIMESTAMP_W-1:0] jitter;
      logic [TIMESTAMP_W-1:0] minute_period;
      logic [TIMESTAMP_W-1:0] drift;
   } slot_pulse_type;

   logic clock;
   logic reset;

   tcst_req_if req_ch ();
   tcst_rsp_if rsp_ch ();

   time_code_slot_transmitter_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // transmitter state as predicted
   symbol_type             frame_a [64];
   symbol_type             frame_b [64];
   logic                   active_b;
   logic                   staged;
   logic [SLOT_W-1:0]      next_slot;
   logic [TIMESTAMP_W-1:0] last_tick_us;
   logic                   tick_seen;
   logic [TIMESTAMP_W-1:0] minute_start_us;
   logic                   minute_seen;
   logic [TIMESTAMP_W-1:0] minute_len_us;
   logic [TIMESTAMP_W-1:0] peak_jitter_us;
   logic [TIMESTAMP_W-1:0] peak_drift_us;

   slot_pulse_type         pulses_due [$];
   logic [TIMESTAMP_W-1:0] tick_clock;
   int                     requests_done;
   int                     pulses_checked;
   int                     swaps_seen;
   int                     wraps_seen;
   int                     errors;
   int                     burst_left;
   bit                     steady_sender;
   int                     receiver_hold;
   int                     cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [TIMESTAMP_W-1:0] deviation(logic [TIMESTAMP_W-1:0] v,
                                                        longint unsigned nominal);
      longint unsigned w;
      w = 64'(v);
      return (w >= nominal) ? TIMESTAMP_W'(w - nominal) : TIMESTAMP_W'(nominal - w);
   endfunction

   function automatic bit predict_pulse(input slot_request_type r, output slot_pulse_type p);
      logic                   to_b;
      logic [TIMESTAMP_W-1:0] dev;
      if (r.cmd == CMD_WRITE) begin
         if (r.slot_index < SLOTS) begin
            to_b = r.to_active ? active_b : !active_b;
            if (to_b)
               frame_b[r.slot_index] = r.symbol;
            else
               frame_a[r.slot_index] = r.symbol;
         end
         return 1'b0;
      end
      if (r.cmd == CMD_READY) begin
         staged = 1'b1;
         return 1'b0;
      end
      if (r.cmd == CMD_RESTART) begin
         next_slot = '0;
         return 1'b0;
      end

      p.second_period = '0;
      if (tick_seen) begin
         p.second_period = r.timestamp_us - last_tick_us;
         dev = deviation(p.second_period, USEC_SECOND);
         if (dev > peak_jitter_us)
            peak_jitter_us = dev;
      end
      last_tick_us = r.timestamp_us;
      tick_seen    = 1'b1;

      p.swapped = 1'b0;
      p.request = 1'b0;
      if (next_slot == 0) begin
         if (minute_seen) begin
            minute_len_us = r.timestamp_us - minute_start_us;
            dev = deviation(minute_len_us, USEC_MINUTE);
            if (dev > peak_drift_us)
               peak_drift_us = dev;
         end
         minute_start_us = r.timestamp_us;
         minute_seen     = 1'b1;
         if (staged) begin
            active_b  = !active_b;
            staged    = 1'b0;
            p.swapped = 1'b1;
         end
         p.request = 1'b1;
      end

      p.slot   = next_slot;
      p.symbol = active_b ? frame_b[next_slot] : frame_a[next_slot];
      case (p.symbol)
         SYM_ZERO:   p.low_time = LOW_TIME_ZERO_US;
         SYM_ONE:    p.low_time = LOW_TIME_ONE_US;
         SYM_MARKER: p.low_time = LOW_TIME_MARKER_US;
         default:    p.low_time = LOW_TIME_NONE_US;
      endcase
      p.carrier_off = (p.symbol != SYM_NONE);

      if (next_slot == SLOTS - 1) begin
         next_slot = '0;
         p.wrapped = 1'b1;
      end else begin
         next_slot = next_slot + 1'b1;
         p.wrapped = 1'b0;
      end

      p.jitter        = peak_jitter_us;
      p.minute_period = minute_len_us;
      p.drift         = peak_drift_us;
      return 1'b1;
   endfunction

   function automatic slot_request_type noise_request(cmd_type c);
      slot_request_type r;
      r.cmd          = c;
      r.to_active    = 1'($urandom_range(0, 1));
      r.slot_index   = SLOT_W'($urandom_range(0, 63));
      r.symbol       = symbol_type'($urandom_range(0, 3));
      r.timestamp_us = TIMESTAMP_W'({$urandom, $urandom});
      return r;
   endfunction

   function automatic logic [TIMESTAMP_W-1:0] next_second();
      if ($urandom_range(0, 49) == 0)
         return TIMESTAMP_W'(64'(tick_clock) + 64'($urandom_range(2, 4)) * USEC_SECOND);
      return TIMESTAMP_W'(64'(tick_clock) + USEC_SECOND - 64'd3000 + 64'($urandom_range(0, 6000)));
   endfunction

   task automatic send_request(input slot_request_type r);
      slot_pulse_type p;
      int             gap;
      if (!steady_sender && burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= r.cmd;
      req_ch.to_active    <= r.to_active;
      req_ch.slot_index   <= r.slot_index;
      req_ch.symbol       <= r.symbol;
      req_ch.timestamp_us <= r.timestamp_us;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (predict_pulse(r, p))
         pulses_due.push_back(p);
      if (!(r.cmd == CMD_WRITE && r.slot_index >= SLOTS))
         requests_done++;
   endtask

   task automatic send_tick(input logic [TIMESTAMP_W-1:0] ts);
      slot_request_type r;
      r = noise_request(CMD_TICK);
      r.timestamp_us = ts;
      tick_clock = ts;
      send_request(r);
   endtask

   task automatic send_write(input logic to_active, input int slot, input symbol_type sym);
      slot_request_type r;
      r = noise_request(CMD_WRITE);
      r.to_active  = to_active;
      r.slot_index = SLOT_W'(slot);
      r.symbol     = sym;
      send_request(r);
   endtask

   task automatic send_command(input cmd_type c);
      send_request(noise_request(c));
   endtask

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 40)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("slot response %0d %s: got %0h, expected %0h",
                                   pulses_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      slot_pulse_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pulses_due.size() == 0) begin
            report_mismatch($sformatf("response for slot %0d with none pending",
                                      rsp_ch.sent_slot));
         end else begin
            want = pulses_due.pop_front();
            check_field("sent_slot", 64'(rsp_ch.sent_slot), 64'(want.slot));
            check_field("sent_symbol", 64'(rsp_ch.sent_symbol), 64'(want.symbol));
            check_field("carrier_off", 64'(rsp_ch.carrier_off), 64'(want.carrier_off));
            check_field("low_time_us", 64'(rsp_ch.low_time_us), 64'(want.low_time));
            check_field("frame_swapped", 64'(rsp_ch.frame_swapped), 64'(want.swapped));
            check_field("frame_request", 64'(rsp_ch.frame_request), 64'(want.request));
            check_field("minute_done", 64'(rsp_ch.minute_done), 64'(want.wrapped));
            check_field("tick_interval_us", 64'(rsp_ch.tick_interval_us),
                        64'(want.second_period));
            check_field("peak_second_jitter_us", 64'(rsp_ch.peak_second_jitter_us),
                        64'(want.jitter));
            check_field("minute_length_us", 64'(rsp_ch.minute_length_us),
                        64'(want.minute_period));
            check_field("peak_minute_drift_us", 64'(rsp_ch.peak_minute_drift_us),
                        64'(want.drift));
            pulses_checked++;
            swaps_seen += want.swapped;
            wraps_seen += want.wrapped;
         end
      end
   end

   // response side: random stall patterns, plus a long hold-off on demand
   initial begin
      logic [31:0] stall_bits;
      int          mode;
      int          left;
      rsp_ch.ready <= 1'b0;
      stall_bits = '1;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (receiver_hold > 0) begin
            receiver_hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (left == 0) begin
               left = $urandom_range(8, 80);
               mode = $urandom_range(0, 3);
               stall_bits = $urandom;
               if (mode == 3)
                  stall_bits &= $urandom;
            end
            left--;
            rsp_ch.ready <= (mode == 0) ? 1'b1 : stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[31:1]};
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d responses pending",
               cycle_count, pulses_due.size());
      $display("Regression FAIL");
      $finish;
   end

   task automatic test_first_ticks;
      send_tick('0);
      send_tick(TIMESTAMP_W'(USEC_SECOND));
   endtask

   task automatic test_symbol_table;
      send_write(1'b1, 2, SYM_ONE);
      send_write(1'b1, 3, SYM_MARKER);
      send_write(1'b1, 4, SYM_NONE);
      send_write(1'b1, 5, SYM_ZERO);
      send_write(1'b1, 60, SYM_NONE);
      send_write(1'b0, 63, SYM_MARKER);
      repeat (4) send_tick(next_second());
   endtask

   task automatic test_frame_swap;
      send_write(1'b0, 0, SYM_MARKER);
      send_write(1'b0, SLOTS - 1, SYM_NONE);
      send_command(CMD_READY);
      send_command(CMD_READY);
      send_command(CMD_RESTART);
      send_tick(next_second());
      send_tick(next_second());
   endtask

   task automatic test_backpressure;
      steady_sender = 1'b1;
      receiver_hold = HOLD_CYCLES;
      repeat (40) send_tick(next_second());
      steady_sender = 1'b0;
   endtask

   task automatic test_random_minutes;
      int fill;
      int pick;
      bit slow;
      logic [TIMESTAMP_W-1:0] ts;
      while (requests_done < ITEM_TARGET) begin
         fill = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : SLOTS;
         for (int i = 0; i < fill; i++)
            send_write(1'b0, (fill == SLOTS) ? i : $urandom_range(0, 63),
                       symbol_type'($urandom_range(0, 3)));
         if ($urandom_range(0, 5) != 0)
            send_command(CMD_READY);
         if ($urandom_range(0, 7) == 0)
            send_command(CMD_READY);
         slow = ($urandom_range(0, 7) == 0);
         for (int t = 0; t < SLOTS && requests_done < ITEM_TARGET; t++) begin
            if (slow)
               ts = TIMESTAMP_W'(64'(tick_clock) + 64'($urandom_range(2000000, 3000000)));
            else
               ts = next_second();
            send_tick(ts);
            pick = $urandom_range(0, 149);
            if (pick == 0)
               send_command(CMD_RESTART);
            else if (pick == 1)
               send_command(CMD_READY);
            else if (pick < 16)
               send_write(1'b1, $urandom_range(0, 63), symbol_type'($urandom_range(0, 3)));
            else if (pick < 30)
               send_write(1'b0, $urandom_range(0, 63), symbol_type'($urandom_range(0, 3)));
         end
      end
   endtask

   task automatic test_time_wrap;
      send_tick(TIME_MAX);
      send_tick(TIMESTAMP_W'(USEC_SECOND - 1));
   endtask

   initial begin
      for (int i = 0; i < 64; i++) begin
         frame_a[i] = SYM_ZERO;
         frame_b[i] = SYM_ZERO;
      end
      active_b        = 1'b0;
      staged          = 1'b0;
      next_slot       = '0;
      last_tick_us    = '0;
      tick_seen       = 1'b0;
      minute_start_us = '0;
      minute_seen     = 1'b0;
      minute_len_us   = '0;
      peak_jitter_us  = '0;
      peak_drift_us   = '0;
      tick_clock      = '0;
      requests_done   = 0;
      pulses_checked  = 0;
      swaps_seen      = 0;
      wraps_seen      = 0;
      errors          = 0;
      burst_left      = 0;
      steady_sender   = 1'b0;
      receiver_hold   = 0;

      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.cmd          <= CMD_WRITE;
      req_ch.to_active    <= 1'b0;
      req_ch.slot_index   <= '0;
      req_ch.symbol       <= SYM_ZERO;
      req_ch.timestamp_us <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_first_ticks();
      test_symbol_table();
      test_frame_swap();
      test_backpressure();
      test_random_minutes();
      test_time_wrap();
      req_ch.valid <= 1'b0;

      while (pulses_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d slot responses (%0d frame swaps, %0d minutes).",
               requests_done, pulses_checked, swaps_seen, wraps_seen);
      $display("Included a response hold-off, out-of-range writes, restarts and a time wrap.");
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
